>>> design/uv_sphere_vertex_generator_core_macros.svh
// Assertion macros shared by the sphere vertex generator RTL.
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define UVS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define UVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UVS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UVS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/uvs_pkg.sv
// Shared constants, types and helpers of the sphere vertex generator.
package uvs_pkg;
  localparam int WORK_FRAC    = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int ANG_BITS     = 32;
  localparam int CW           = 34;  // cordic datapath width, Q2.30 plus guard
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int REG_RING    = 0;
  localparam int REG_SEGMENT = 1;

  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
        3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
        9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
       12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
       15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
       18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
       21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
       24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
       27: t = 32'h00000005; 28: t = 32'h00000003; default: t = 32'h00000001;
      endcase
      atan_turn = $signed({2'b00, t});
    end
  endfunction

  typedef struct packed {
    logic valid;
    logic [1:0] pquad;
    logic [1:0] aquad;
  } uvs_ctl_t;
endpackage

>>> design/uvs_divider.sv
// Pipelined restoring divider: one quotient bit per stage, floor division.
module uvs_divider import uvs_pkg::*; #(
  parameter int NUM_BITS = 42,
  parameter int DEN_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                out_valid,
  output logic [NUM_BITS-1:0] quo
);
  // numerator is pre-biased by den/2 by the caller; plain floor division here
  logic [NUM_BITS-1:0] q   [NUM_BITS+1];
  logic [DEN_BITS:0]   r   [NUM_BITS+1];
  logic [NUM_BITS-1:0] n   [NUM_BITS+1];
  logic [DEN_BITS-1:0] d   [NUM_BITS+1];
  logic                v   [NUM_BITS+1];

  always_comb begin
    q[0] = '0;
    r[0] = '0;
    n[0] = num;
    d[0] = den;
    v[0] = in_valid;
  end

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    logic [DEN_BITS+1:0] trial;
    logic [DEN_BITS+1:0] shifted;
    always_comb begin
      shifted = {r[s], n[s][NUM_BITS-1-s]};
      trial   = shifted - {2'b00, d[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        n[s+1] <= n[s];
        d[s+1] <= d[s];
        if (!trial[DEN_BITS+1]) begin
          r[s+1] <= trial[DEN_BITS:0];
          q[s+1] <= {q[s][NUM_BITS-2:0], 1'b1};
        end else begin
          r[s+1] <= shifted[DEN_BITS:0];
          q[s+1] <= {q[s][NUM_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[NUM_BITS];
  assign quo       = q[NUM_BITS];
endmodule

>>> design/uvs_cordic.sv
// Pipelined rotation CORDIC: cos and sin of the low 30 bits of a binary angle.
module uvs_cordic import uvs_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [29:0]          angle,
  output logic signed [CW-1:0] cos_out,
  output logic signed [CW-1:0] sin_out
);
  logic signed [CW-1:0] x [CORDIC_STEPS+1];
  logic signed [CW-1:0] y [CORDIC_STEPS+1];
  logic signed [CW-1:0] z [CORDIC_STEPS+1];

  always_comb begin
    x[0] = CORDIC_GAIN;
    y[0] = '0;
    z[0] = $signed({{(CW-30){1'b0}}, angle});
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][CW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_turn(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_turn(i);
        end
      end
    end
  end

  assign cos_out = x[CORDIC_STEPS];
  assign sin_out = y[CORDIC_STEPS];
endmodule

>>> design/uv_sphere_vertex_generator_core.sv
// Top level: saturate indices, divide to angles, CORDIC, multiply, round.
// Pipeline: stage 0, stage 1, (COUNT_BITS+32) divider stages, 30 CORDIC stages, stage A, stage B, output register.
// Throughput: one beat per cycle; the whole pipe advances when the output
// register is empty or being taken, so a stall holds every stage.
// Reset (rst, synchronous): clears all valid bits, ring_count 16, segment_count 32.
`include "uv_sphere_vertex_generator_core_macros.svh"
module uv_sphere_vertex_generator_core import uvs_pkg::*; #(
  parameter int COUNT_BITS = 10,
  parameter int FRAC_BITS  = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [COUNT_BITS-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // ring_index [COUNT_BITS-1:0], segment_index above, zero padded to bytes
  input  logic [((2*COUNT_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z (16 each), tex_u, tex_v (17)
  output logic [135:0]          m_axis_tdata
);
  localparam int NB = COUNT_BITS + ANG_BITS;
  localparam int DLAT = NB;

  logic [COUNT_BITS-1:0] ring_count, segment_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count    <= COUNT_BITS'(16);
      segment_count <= COUNT_BITS'(32);
    end else if (cfg_we) begin
      if (cfg_index == 1'(REG_RING)) ring_count <= cfg_data;
      else segment_count <= cfg_data;
    end
  end

  logic en;
  logic out_full;
  assign en = !out_full || m_axis_tready;
  assign s_axis_tready = en;

  // stage 0: effective counts and saturated indices
  logic [COUNT_BITS-1:0] rc, sc, ri, si, rin, sin_i;
  logic v0;
  always_comb begin
    rin   = s_axis_tdata[COUNT_BITS-1:0];
    sin_i = s_axis_tdata[2*COUNT_BITS-1:COUNT_BITS];
  end
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_axis_tvalid;
    if (en) begin
      rc <= (ring_count == '0) ? COUNT_BITS'(1) : ring_count;
      sc <= (segment_count == '0) ? COUNT_BITS'(1) : segment_count;
      ri <= (rin > ((ring_count == '0) ? COUNT_BITS'(1) : ring_count)) ?
            ((ring_count == '0) ? COUNT_BITS'(1) : ring_count) : rin;
      si <= (sin_i > ((segment_count == '0) ? COUNT_BITS'(1) : segment_count)) ?
            ((segment_count == '0) ? COUNT_BITS'(1) : segment_count) : sin_i;
    end
  end

  // stage 1: biased numerators (index * 2^32 + count/2; polar uses 2^31)
  logic [NB-1:0] pnum, anum;
  logic [COUNT_BITS-1:0] rc1, sc1;
  logic v1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) begin
      pnum <= {1'b0, ri, 31'b0} + NB'(rc >> 1);
      anum <= {si, 32'b0} + NB'(sc >> 1);
      rc1 <= rc;
      sc1 <= sc;
    end
  end

  logic dv_p, dv_a;
  logic [NB-1:0] pq, aq;
  uvs_divider #(.NUM_BITS(NB), .DEN_BITS(COUNT_BITS)) u_div_p (
    .clk, .rst, .en, .in_valid(v1), .num(pnum), .den(rc1),
    .out_valid(dv_p), .quo(pq));
  uvs_divider #(.NUM_BITS(NB), .DEN_BITS(COUNT_BITS)) u_div_a (
    .clk, .rst, .en, .in_valid(v1), .num(anum), .den(sc1),
    .out_valid(dv_a), .quo(aq));

  // texture rounding from the 2^32 quotient differs from direct rounding only
  // in rare ties; compute exact values with side dividers instead
  logic [NB-1:0] tunum, tvnum, tuq, tvq;
  logic tuv, tvv;
  always_ff @(posedge clk) begin
    if (en) begin
      tunum <= NB'({si, 16'b0}) + NB'(sc >> 1);
      tvnum <= NB'({ri, 16'b0}) + NB'(rc >> 1);
    end
  end
  uvs_divider #(.NUM_BITS(NB), .DEN_BITS(COUNT_BITS)) u_div_u (
    .clk, .rst, .en, .in_valid(v1), .num(tunum), .den(sc1),
    .out_valid(tuv), .quo(tuq));
  uvs_divider #(.NUM_BITS(NB), .DEN_BITS(COUNT_BITS)) u_div_v (
    .clk, .rst, .en, .in_valid(v1), .num(tvnum), .den(rc1),
    .out_valid(tvv), .quo(tvq));

  logic [31:0] polar, azim;
  assign polar = pq[31:0];
  assign azim  = aq[31:0];

  logic signed [CW-1:0] pc, ps, ac, as_;
  uvs_cordic u_cor_p (.clk, .en, .angle(polar[29:0]), .cos_out(pc), .sin_out(ps));
  uvs_cordic u_cor_a (.clk, .en, .angle(azim[29:0]), .cos_out(ac), .sin_out(as_));

  // quadrant and texture values ride alongside the CORDIC
  uvs_ctl_t ctl [CORDIC_STEPS+1];
  logic [16:0] tu_p [CORDIC_STEPS+1];
  logic [16:0] tv_p [CORDIC_STEPS+1];
  always_comb begin
    ctl[0].valid = dv_p;
    ctl[0].pquad = polar[31:30];
    ctl[0].aquad = azim[31:30];
    tu_p[0] = tuq[16:0];
    tv_p[0] = tvq[16:0];
  end
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) ctl[k+1].valid <= 1'b0;
      else if (en) ctl[k+1].valid <= ctl[k].valid;
      if (en) begin
        ctl[k+1].pquad <= ctl[k].pquad;
        ctl[k+1].aquad <= ctl[k].aquad;
        tu_p[k+1] <= tu_p[k];
        tv_p[k+1] <= tv_p[k];
      end
    end
  end

  function automatic void quad_map(input logic [1:0] q, input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y,
                                   output logic signed [CW-1:0] c,
                                   output logic signed [CW-1:0] s);
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  uvs_ctl_t cend;
  assign cend = ctl[CORDIC_STEPS];

  // stage A: quadrant mapping
  logic signed [CW-1:0] ct, st, cp, sp;
  logic signed [CW-1:0] ct_c, st_c, cp_c, sp_c;
  logic va;
  logic [16:0] tua, tva;
  always_comb begin
    quad_map(cend.pquad, pc, ps, ct_c, st_c);
    quad_map(cend.aquad, ac, as_, cp_c, sp_c);
  end
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= cend.valid;
    if (en) begin
      ct <= ct_c; st <= st_c; cp <= cp_c; sp <= sp_c;
      tua <= tu_p[CORDIC_STEPS]; tva <= tv_p[CORDIC_STEPS];
    end
  end

  // stage B: products
  logic signed [2*CW-1:0] px, pz;
  logic signed [CW-1:0] vy;
  logic vb;
  logic [16:0] tub, tvb;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
    if (en) begin
      px <= st * cp;
      pz <= st * sp;
      vy <= ct;
      tub <= tua; tvb <= tva;
    end
  end

  function automatic logic signed [15:0] rnd_sat(input logic signed [2*CW-1:0] v,
                                                input int frac,
                                                input logic signed [31:0] lo,
                                                input logic signed [31:0] hi);
    logic signed [2*CW-1:0] r;
    begin
      r = (v + ((2*CW)'(1) <<< (WORK_FRAC - frac - 1))) >>> (WORK_FRAC - frac);
      if (r < (2*CW)'(lo)) r = (2*CW)'(lo);
      if (r > (2*CW)'(hi)) r = (2*CW)'(hi);
      rnd_sat = r[15:0];
    end
  endfunction

  localparam logic signed [31:0] NLO = -(32'sd1 <<< FRAC_BITS);
  localparam logic signed [31:0] NHI = (32'sd1 <<< FRAC_BITS) - 32'sd1;
  localparam logic signed [31:0] PLO = -(32'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [31:0] PHI = (32'sd1 <<< (FRAC_BITS - 1));

  logic signed [2*CW-1:0] vx, vz, vye;
  always_comb begin
    vx  = px >>> WORK_FRAC;
    vz  = pz >>> WORK_FRAC;
    vye = (2*CW)'(vy);
  end

  // output register
  logic [135:0] out_d;
  always_comb begin
    out_d = {6'd0, tvb, tub,
             rnd_sat(vz, FRAC_BITS, NLO, NHI), rnd_sat(vye, FRAC_BITS, NLO, NHI),
             rnd_sat(vx, FRAC_BITS, NLO, NHI),
             rnd_sat(vz, FRAC_BITS-1, PLO, PHI), rnd_sat(vye, FRAC_BITS-1, PLO, PHI),
             rnd_sat(vx, FRAC_BITS-1, PLO, PHI)};
  end
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (en) out_full <= vb;
    if (en) m_axis_tdata <= out_d;
  end
  assign m_axis_tvalid = out_full;

  `UVS_ASSERT_IMPL(a_div_lockstep, clk, rst, 1'b1, {dv_a, tuv, tvv} == {3{dv_p}})
  `UVS_ASSERT_NEXT(a_stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `UVS_ASSERT_IMPL(a_ready_when_empty, clk, rst, !out_full, s_axis_tready)
endmodule

>>> verif/uv_sphere_vertex_generator_core_test.sv
// Self-checking testbench for the UV sphere vertex generator core.
module uv_sphere_vertex_generator_core_test;
  import uvs_pkg::*;

  localparam int CB        = 10;
  localparam int FB        = 15;
  localparam int LATENCY   = 2 + (CB + 32) + 30 + 3;
  localparam int DOG_LIMIT = 4000;

  typedef struct packed {
    logic [16:0]        tex_v;
    logic [16:0]        tex_u;
    logic signed [15:0] nrm_z;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_x;
    logic signed [15:0] pos_z;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
  } vertex_t;

  class vertex_board;
    vertex_t     pending_vertices[$];
    logic [CB-1:0] rings, segs;
    int          errors;

    function new();
      rings = 16;
      segs = 32;
      errors = 0;
    endfunction

    function void set_count(logic idx, logic [CB-1:0] val);
      if (idx == REG_RING) rings = val;
      else segs = val;
    endfunction

    // quadrant-folded CORDIC rotation of a 32-bit binary angle, Q2.30 out
    function void rotate(logic [31:0] ang, output longint c, output longint s);
      longint tab[30];
      longint x, y, z, dx, dy;
      tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
              64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
              64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
              64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
              64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
              64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
      x = 652032874;
      y = 0;
      z = longint'(ang[29:0]);
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= tab[i];
        end else begin
          x += dx; y -= dy; z += tab[i];
        end
      end
      case (ang[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint round_clip(longint v, int frac, longint lo, longint hi);
      int sh;
      longint r;
      sh = 30 - frac;
      r = (v + (longint'(1) << (sh - 1))) >>> sh;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
    endfunction

    function vertex_t predict_vertex(logic [CB-1:0] ring_in, logic [CB-1:0] seg_in);
      longint rc, sc, ring, seg, ct, st, cp, sp;
      longint v[3];
      logic [31:0] polar, azim;
      vertex_t e;
      rc = (rings == 0) ? 1 : rings;
      sc = (segs == 0) ? 1 : segs;
      ring = (ring_in > rc) ? rc : ring_in;
      seg = (seg_in > sc) ? sc : seg_in;
      polar = 32'(((ring << 31) + rc / 2) / rc);
      azim = 32'(((seg << 32) + sc / 2) / sc);
      rotate(polar, ct, st);
      rotate(azim, cp, sp);
      v[0] = (st * cp) >>> 30;
      v[1] = ct;
      v[2] = (st * sp) >>> 30;
      e.pos_x = 16'(round_clip(v[0], FB - 1, -(1 <<< (FB - 1)), 1 <<< (FB - 1)));
      e.pos_y = 16'(round_clip(v[1], FB - 1, -(1 <<< (FB - 1)), 1 <<< (FB - 1)));
      e.pos_z = 16'(round_clip(v[2], FB - 1, -(1 <<< (FB - 1)), 1 <<< (FB - 1)));
      e.nrm_x = 16'(round_clip(v[0], FB, -(1 <<< FB), (1 <<< FB) - 1));
      e.nrm_y = 16'(round_clip(v[1], FB, -(1 <<< FB), (1 <<< FB) - 1));
      e.nrm_z = 16'(round_clip(v[2], FB, -(1 <<< FB), (1 <<< FB) - 1));
      e.tex_u = 17'((seg * 65536 + sc / 2) / sc);
      e.tex_v = 17'((ring * 65536 + rc / 2) / rc);
      return e;
    endfunction

    function void note_point(logic [CB-1:0] ring_in, logic [CB-1:0] seg_in);
      pending_vertices = {pending_vertices, predict_vertex(ring_in, seg_in)};
    endfunction

    function void check_vertex(logic [135:0] data);
      vertex_t got, e;
      got = vertex_t'(data[129:0]);
      if (pending_vertices.size() == 0) begin
        $error("unexpected output beat %h", data);
        errors++;
        return;
      end
      e = pending_vertices.pop_front();
      if (got.pos_x !== e.pos_x) begin
        $error("pos_x exp %0d got %0d", e.pos_x, got.pos_x); errors++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("pos_y exp %0d got %0d", e.pos_y, got.pos_y); errors++;
      end
      if (got.pos_z !== e.pos_z) begin
        $error("pos_z exp %0d got %0d", e.pos_z, got.pos_z); errors++;
      end
      if (got.nrm_x !== e.nrm_x) begin
        $error("normal_x exp %0d got %0d", e.nrm_x, got.nrm_x); errors++;
      end
      if (got.nrm_y !== e.nrm_y) begin
        $error("normal_y exp %0d got %0d", e.nrm_y, got.nrm_y); errors++;
      end
      if (got.nrm_z !== e.nrm_z) begin
        $error("normal_z exp %0d got %0d", e.nrm_z, got.nrm_z); errors++;
      end
      if (got.tex_u !== e.tex_u) begin
        $error("tex_u exp %0d got %0d", e.tex_u, got.tex_u); errors++;
      end
      if (got.tex_v !== e.tex_v) begin
        $error("tex_v exp %0d got %0d", e.tex_v, got.tex_v); errors++;
      end
      if (data[135:130] !== 6'd0) begin
        $error("pad exp 0 got %h", data[135:130]); errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic          cfg_index = 1'b0;
  logic [CB-1:0] cfg_data = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [23:0]   s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [135:0]  m_axis_tdata;

  vertex_board board = new();
  int  src_idle = 0;
  int  sink_stall = 0;
  bit  hold_go = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_cnt = 0;
  int  dog = 0;

  uv_sphere_vertex_generator_core #(.COUNT_BITS(CB), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_cnt <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_vertex(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready)
        || (m_axis_tvalid && m_axis_tready)) begin
      dog = 0;
    end else begin
      dog++;
      if (dog >= DOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (board.pending_vertices.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_count(logic idx, logic [CB-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_count(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_counts(logic [CB-1:0] r, logic [CB-1:0] s);
    wait_drained();
    write_count(REG_RING, r);
    write_count(REG_SEGMENT, s);
  endtask

  task automatic send_point(logic [CB-1:0] r, logic [CB-1:0] s);
    if (src_idle > 0 && $urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, s, r};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_point(r, s);
  endtask

  task automatic random_points(int n);
    int rc, sc;
    rc = (board.rings == 0) ? 1 : board.rings;
    sc = (board.segs == 0) ? 1 : board.segs;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 85)
        send_point(CB'($urandom_range(0, rc)), CB'($urandom_range(0, sc)));
      else
        send_point(CB'($urandom), CB'($urandom));
    end
  endtask

  initial begin
    logic [CB-1:0] rsel, ssel;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset counts, poles, equator, full turn, saturation
    send_point(0, 0);
    send_point(16, 0);
    send_point(8, 0);
    send_point(8, 8);
    send_point(8, 16);
    send_point(8, 24);
    send_point(8, 32);
    send_point(1023, 1023);
    send_point(17, 33);
    send_point(4, 5);
    send_point(12, 27);
    s_axis_tvalid <= 1'b0;
    set_counts(0, 0);
    send_point(0, 0);
    send_point(1, 1);
    send_point(1023, 512);
    s_axis_tvalid <= 1'b0;
    set_counts(1023, 1023);
    send_point(0, 0);
    send_point(1023, 1023);
    send_point(511, 256);
    send_point(512, 767);
    send_point(10'h2AA, 10'h155);
    send_point(10'h155, 10'h2AA);
    s_axis_tvalid <= 1'b0;
    set_counts(1, 1);
    send_point(0, 1);
    send_point(1, 0);
    send_point(2, 2);

    for (int ph = 0; ph < 8; ph++) begin
      s_axis_tvalid <= 1'b0;
      case ($urandom_range(0, 3))
        0: rsel = 1023;
        1: rsel = CB'($urandom_range(0, 3));
        default: rsel = CB'($urandom_range(1, 1023));
      endcase
      case ($urandom_range(0, 3))
        0: ssel = 1023;
        1: ssel = CB'($urandom_range(0, 3));
        default: ssel = CB'($urandom_range(1, 1023));
      endcase
      if (ph == 0) begin
        rsel = 1023; ssel = 1023;
      end
      set_counts(rsel, ssel);
      src_idle = (ph % 4 == 1) ? 46 : (ph % 4 == 3) ? 21 : 0;
      sink_stall = (ph % 4 == 2) ? 46 : (ph % 4 == 3) ? 21 : 0;
      if (ph == 2) hold_go = ~hold_go;
      random_points(100);
      if (ph == 5) begin
        s_axis_tvalid <= 1'b0;
        while (board.pending_vertices.size() != 0) @(posedge clk);
      end
      random_points(100);
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending_vertices.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (board.errors == 0 && board.pending_vertices.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/uvs_pkg.sv
design/uvs_divider.sv
design/uvs_cordic.sv
design/uv_sphere_vertex_generator_core.sv
verif/uv_sphere_vertex_generator_core_test.sv
